// ===== src/tcc_pkg.sv =====
// tcc_pkg: shared widths, constants and types of the threshold centroid block
// no dependencies; imported by every module under src
`default_nettype none

package tcc_pkg;

  localparam int CH_COUNT    = 3;
  localparam int CH_W        = 2;
  localparam int LEVEL_W     = 8;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 8;
  localparam int COL_SUM_W   = 27;
  localparam int ROW_SUM_W   = 25;
  localparam int COUNT_W     = 18;
  localparam int MAX_COLUMNS = 512;
  localparam int MAX_ROWS    = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = COL_SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 8'd230;

  // apb register map
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic CFG_IDX_THRESHOLD = 1'b0;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CH_COUNT - 1);

  typedef struct packed {
    logic [CH_COUNT-1:0][COL_SUM_W-1:0] col_sum;
    logic [CH_COUNT-1:0][ROW_SUM_W-1:0] row_sum;
    logic [CH_COUNT-1:0][COUNT_W-1:0]   count;
  } frame_sums_t;

  typedef struct packed {
    logic [CH_COUNT-1:0][COL_W-1:0] center_x;
    logic [CH_COUNT-1:0][ROW_W-1:0] center_y;
    logic [CH_COUNT-1:0]            found;
  } result_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_START,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/tcc_front.sv =====
// tcc_front: thresholds each pixel and keeps the per-channel sums and counts
// depends on tcc_pkg; hands a snapshot of the sums to tcc_queue at frame end
`default_nettype none

module tcc_front
  import tcc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [LEVEL_W-1:0] threshold,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [LEVEL_W-1:0] in_red_level,
  input  wire logic [LEVEL_W-1:0] in_green_level,
  input  wire logic [LEVEL_W-1:0] in_blue_level,
  input  wire logic [COL_W-1:0]   in_pixel_column,
  input  wire logic [ROW_W-1:0]   in_pixel_row,
  input  wire logic               in_frame_end,
  input  wire logic               q_full,
  output logic                    q_push,
  output frame_sums_t             q_data
);

  logic [CH_COUNT-1:0][COL_SUM_W-1:0] col_sum_r, col_sum_nxt, col_sum_upd;
  logic [CH_COUNT-1:0][ROW_SUM_W-1:0] row_sum_r, row_sum_nxt, row_sum_upd;
  logic [CH_COUNT-1:0][COUNT_W-1:0]   count_r, count_nxt, count_upd;
  logic [CH_COUNT-1:0][COL_SUM_W:0]   col_add;
  logic [CH_COUNT-1:0][ROW_SUM_W:0]   row_add;
  logic [CH_COUNT-1:0][LEVEL_W-1:0]   levels;
  logic [CH_COUNT-1:0]                hit;
  logic                               in_frame;
  logic                               accept;

  assign levels   = {in_blue_level, in_green_level, in_red_level};
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_frame = (32'(in_pixel_column) < 32'(MAX_COLUMNS)) &&
                    (32'(in_pixel_row) < 32'(MAX_ROWS));

  always_comb begin
    for (int ch = 0; ch < CH_COUNT; ch++) begin
      col_add[ch] = {1'b0, col_sum_r[ch]} + (COL_SUM_W+1)'(in_pixel_column);
      row_add[ch] = {1'b0, row_sum_r[ch]} + (ROW_SUM_W+1)'(in_pixel_row);
      // a hit that would overflow any accumulator is dropped whole
      hit[ch] = in_frame && (levels[ch] > threshold) && (count_r[ch] != '1) &&
                !col_add[ch][COL_SUM_W] && !row_add[ch][ROW_SUM_W];
      col_sum_upd[ch] = hit[ch] ? col_add[ch][COL_SUM_W-1:0] : col_sum_r[ch];
      row_sum_upd[ch] = hit[ch] ? row_add[ch][ROW_SUM_W-1:0] : row_sum_r[ch];
      count_upd[ch]   = hit[ch] ? count_r[ch] + COUNT_W'(1) : count_r[ch];
    end

    q_push         = accept && in_frame_end;
    q_data.col_sum = col_sum_upd;
    q_data.row_sum = row_sum_upd;
    q_data.count   = count_upd;

    col_sum_nxt = col_sum_r;
    row_sum_nxt = row_sum_r;
    count_nxt   = count_r;
    if (accept) begin
      if (in_frame_end) begin
        col_sum_nxt = '0;
        row_sum_nxt = '0;
        count_nxt   = '0;
      end else begin
        col_sum_nxt = col_sum_upd;
        row_sum_nxt = row_sum_upd;
        count_nxt   = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_sum_r <= '0;
      row_sum_r <= '0;
      count_r   <= '0;
    end else begin
      col_sum_r <= col_sum_nxt;
      row_sum_r <= row_sum_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tcc_queue.sv =====
// tcc_queue: short fifo of finished frame sums between front and back
// depends on tcc_pkg
`default_nettype none

module tcc_queue
  import tcc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire frame_sums_t  push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output frame_sums_t       head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  frame_sums_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic                     do_push, do_pop;

  assign full       = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/tcc_back.sv =====
// tcc_back: divides the frame sums channel by channel and holds the centroids
// depends on tcc_pkg; takes frames from tcc_queue, drives the result register
`default_nettype none

module tcc_back
  import tcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire frame_sums_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_result
);

  back_state_t                        state_r, state_nxt;
  frame_sums_t                        frame_r, frame_nxt;
  logic [CH_W-1:0]                    ch_r, ch_nxt;
  logic [STEP_W-1:0]                  step_r, step_nxt;
  logic [COUNT_W-1:0]                 divisor_r, divisor_nxt;
  logic [COL_SUM_W-1:0]               quo_x_r, quo_x_nxt, quo_x_step;
  logic [COL_SUM_W-1:0]               quo_y_r, quo_y_nxt, quo_y_step;
  logic [COUNT_W-1:0]                 rem_x_r, rem_x_nxt, rem_x_step;
  logic [COUNT_W-1:0]                 rem_y_r, rem_y_nxt, rem_y_step;
  logic [COUNT_W:0]                   shift_x, shift_y;
  logic                               ge_x, ge_y;
  logic [CH_COUNT-1:0][COL_W-1:0]     held_x_r, held_x_nxt;
  logic [CH_COUNT-1:0][ROW_W-1:0]     held_y_r, held_y_nxt;
  logic [CH_COUNT-1:0]                found_r, found_nxt;
  logic                               out_valid_r, out_valid_nxt;
  result_t                            out_result_r, out_result_nxt;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // one restoring step for column and row quotients, shared divisor
  always_comb begin
    shift_x    = {rem_x_r, quo_x_r[COL_SUM_W-1]};
    shift_y    = {rem_y_r, quo_y_r[COL_SUM_W-1]};
    ge_x       = shift_x >= {1'b0, divisor_r};
    ge_y       = shift_y >= {1'b0, divisor_r};
    rem_x_step = ge_x ? COUNT_W'(shift_x - {1'b0, divisor_r}) : shift_x[COUNT_W-1:0];
    rem_y_step = ge_y ? COUNT_W'(shift_y - {1'b0, divisor_r}) : shift_y[COUNT_W-1:0];
    quo_x_step = {quo_x_r[COL_SUM_W-2:0], ge_x};
    quo_y_step = {quo_y_r[COL_SUM_W-2:0], ge_y};
  end

  always_comb begin
    state_nxt      = state_r;
    frame_nxt      = frame_r;
    ch_nxt         = ch_r;
    step_nxt       = step_r;
    divisor_nxt    = divisor_r;
    quo_x_nxt      = quo_x_r;
    quo_y_nxt      = quo_y_r;
    rem_x_nxt      = rem_x_r;
    rem_y_nxt      = rem_y_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    found_nxt      = found_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r && out_stall;
    q_pop          = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          frame_nxt = q_data;
          ch_nxt    = '0;
          state_nxt = B_START;
        end
      end
      B_START: begin
        if (frame_r.count[ch_r] == '0) begin
          // no hits: keep the old centroid
          found_nxt[ch_r] = 1'b0;
          if (ch_r == CH_LAST) begin
            state_nxt = B_DONE;
          end else begin
            ch_nxt = ch_r + CH_W'(1);
          end
        end else begin
          divisor_nxt = frame_r.count[ch_r];
          quo_x_nxt   = frame_r.col_sum[ch_r];
          quo_y_nxt   = COL_SUM_W'(frame_r.row_sum[ch_r]);
          rem_x_nxt   = '0;
          rem_y_nxt   = '0;
          step_nxt    = '0;
          state_nxt   = B_DIV;
        end
      end
      B_DIV: begin
        quo_x_nxt = quo_x_step;
        quo_y_nxt = quo_y_step;
        rem_x_nxt = rem_x_step;
        rem_y_nxt = rem_y_step;
        step_nxt  = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          held_x_nxt[ch_r] = quo_x_step[COL_W-1:0];
          held_y_nxt[ch_r] = quo_y_step[ROW_W-1:0];
          found_nxt[ch_r]  = 1'b1;
          if (ch_r == CH_LAST) begin
            state_nxt = B_DONE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = B_START;
          end
        end
      end
      B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_result_nxt.center_x = held_x_r;
          out_result_nxt.center_y = held_y_r;
          out_result_nxt.found    = found_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ch_r        <= '0;
      step_r      <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      step_r      <= step_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r      <= frame_nxt;
    divisor_r    <= divisor_nxt;
    quo_x_r      <= quo_x_nxt;
    quo_y_r      <= quo_y_nxt;
    rem_x_r      <= rem_x_nxt;
    rem_y_r      <= rem_y_nxt;
    out_result_r <= out_result_nxt;
  end

endmodule

`default_nettype wire

// ===== src/three_channel_threshold_centroid_top.sv =====
// three_channel_threshold_centroid_top: per-channel centroid of bright pixels
// depends on tcc_pkg, tcc_front, tcc_queue, tcc_back
//
// pixels enter on the in_ channel, one per cycle while in_stall is low, and are
// thresholded and summed at once; in_stall rises only while both queue slots
// hold finished frames. the pixel with in_frame_end closes the frame: its sums
// go into a two-entry queue and the accumulators clear in the same cycle.
// the back end divides each channel's column and row sums by its hit count
// with a restoring divider, one quotient bit per cycle: it takes a frame from
// the queue, runs the divider for each channel with hits, skips a channel
// without hits, then loads the result before it takes the next frame.
// one result per frame; out_valid stays high with the result steady while
// out_stall is high, and the back end then waits before loading the next.
// reset clears the sums, the held centroids, the queue and out_valid, and
// sets the threshold to 230. the threshold sits at apb address 0.
`default_nettype none

module three_channel_threshold_centroid_top
  import tcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [LEVEL_W-1:0]    in_red_level,
  input  wire logic [LEVEL_W-1:0]    in_green_level,
  input  wire logic [LEVEL_W-1:0]    in_blue_level,
  input  wire logic [COL_W-1:0]      in_pixel_column,
  input  wire logic [ROW_W-1:0]      in_pixel_row,
  input  wire logic                  in_frame_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COL_W-1:0]           out_red_center_x,
  output logic [ROW_W-1:0]           out_red_center_y,
  output logic [COL_W-1:0]           out_green_center_x,
  output logic [ROW_W-1:0]           out_green_center_y,
  output logic [COL_W-1:0]           out_blue_center_x,
  output logic [ROW_W-1:0]           out_blue_center_y,
  output logic                       out_red_found,
  output logic                       out_green_found,
  output logic                       out_blue_found
);

  logic [LEVEL_W-1:0] threshold_r, threshold_nxt;
  logic               cfg_write;
  logic               q_push;
  logic               q_full;
  frame_sums_t        q_push_data;
  frame_sums_t        q_head_data;
  logic               q_head_valid;
  logic               q_pop;
  result_t            result;

  // register file: byte lanes ignored, word index in paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    threshold_nxt = threshold_r;
    if (cfg_write && (paddr[2] == CFG_IDX_THRESHOLD)) begin
      threshold_nxt = pwdata[LEVEL_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == CFG_IDX_THRESHOLD) begin
      prdata = CFG_DATA_W'(threshold_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else begin
      threshold_r <= threshold_nxt;
    end
  end

  tcc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .threshold       (threshold_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red_level    (in_red_level),
    .in_green_level  (in_green_level),
    .in_blue_level   (in_blue_level),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .in_frame_end    (in_frame_end),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_push_data)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  tcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_head_valid),
    .q_data     (q_head_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (result)
  );

  assign out_red_center_x   = result.center_x[0];
  assign out_red_center_y   = result.center_y[0];
  assign out_green_center_x = result.center_x[1];
  assign out_green_center_y = result.center_y[1];
  assign out_blue_center_x  = result.center_x[2];
  assign out_blue_center_y  = result.center_y[2];
  assign out_red_found      = result.found[0];
  assign out_green_found    = result.found[1];
  assign out_blue_found     = result.found[2];

  // a frame end must never be pushed into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("frame sums pushed into full queue");

  // the back end only takes a frame that the queue holds
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  // no result straight after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

`default_nettype wire

// ===== dv/tb_three_channel_threshold_centroid_top.sv =====
// tb_three_channel_threshold_centroid_top: self-checking bench for the centroid block
// depends on tcc_pkg and three_channel_threshold_centroid_top; a built-in predictor
// follows every pixel request and checks each centroid result field by field
`default_nettype none

module tb_three_channel_threshold_centroid_top;
  import tcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int COL_SUM_MAX  = (1 << COL_SUM_W) - 1;
  localparam int ROW_SUM_MAX  = (1 << ROW_SUM_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = CFG_ADDR_W'(4 * CFG_IDX_THRESHOLD);
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR  = CFG_ADDR_W'(4);
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic [CH_COUNT-1:0][LEVEL_W-1:0] level;
    logic [COL_W-1:0]                 column;
    logic [ROW_W-1:0]                 row;
    logic                             frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [LEVEL_W-1:0] in_red_level = '0;
  logic [LEVEL_W-1:0] in_green_level = '0;
  logic [LEVEL_W-1:0] in_blue_level = '0;
  logic [COL_W-1:0] in_pixel_column = '0;
  logic [ROW_W-1:0] in_pixel_row = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COL_W-1:0] out_red_center_x;
  logic [ROW_W-1:0] out_red_center_y;
  logic [COL_W-1:0] out_green_center_x;
  logic [ROW_W-1:0] out_green_center_y;
  logic [COL_W-1:0] out_blue_center_x;
  logic [ROW_W-1:0] out_blue_center_y;
  logic out_red_found;
  logic out_green_found;
  logic out_blue_found;

  three_channel_threshold_centroid_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_red_level(in_red_level),
    .in_green_level(in_green_level),
    .in_blue_level(in_blue_level),
    .in_pixel_column(in_pixel_column),
    .in_pixel_row(in_pixel_row),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red_center_x(out_red_center_x),
    .out_red_center_y(out_red_center_y),
    .out_green_center_x(out_green_center_x),
    .out_green_center_y(out_green_center_y),
    .out_blue_center_x(out_blue_center_x),
    .out_blue_center_y(out_blue_center_y),
    .out_red_found(out_red_found),
    .out_green_found(out_green_found),
    .out_blue_found(out_blue_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // centroid predictor state
  logic [LEVEL_W-1:0]   thr_model = THRESHOLD_RESET;
  logic [COL_SUM_W-1:0] col_acc [CH_COUNT] = '{default: '0};
  logic [ROW_SUM_W-1:0] row_acc [CH_COUNT] = '{default: '0};
  logic [COUNT_W-1:0]   hit_acc [CH_COUNT] = '{default: '0};
  logic [COL_W-1:0]     hold_x  [CH_COUNT] = '{default: '0};
  logic [ROW_W-1:0]     hold_y  [CH_COUNT] = '{default: '0};

  result_t pending_centroids[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  string ch_name [CH_COUNT] = '{"red", "green", "blue"};

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // adds one accepted pixel to the running sums, closes the frame on frame_end
  task automatic predict_centroids(pixel_t px);
    result_t r;
    if (int'(px.column) < MAX_COLUMNS && int'(px.row) < MAX_ROWS) begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        // a hit that would overflow any accumulator is dropped whole
        if (px.level[ch] > thr_model && hit_acc[ch] != COUNT_MAX &&
            int'(col_acc[ch]) + int'(px.column) <= COL_SUM_MAX &&
            int'(row_acc[ch]) + int'(px.row) <= ROW_SUM_MAX) begin
          col_acc[ch] += COL_SUM_W'(px.column);
          row_acc[ch] += ROW_SUM_W'(px.row);
          hit_acc[ch] += 1'b1;
        end
      end
    end
    if (px.frame_end) begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        r.found[ch] = hit_acc[ch] != '0;
        if (r.found[ch]) begin
          hold_x[ch] = COL_W'(col_acc[ch] / hit_acc[ch]);
          hold_y[ch] = ROW_W'(row_acc[ch] / hit_acc[ch]);
        end
        r.center_x[ch] = hold_x[ch];
        r.center_y[ch] = hold_y[ch];
        col_acc[ch] = '0;
        row_acc[ch] = '0;
        hit_acc[ch] = '0;
      end
      pending_centroids = {pending_centroids, r};
    end
  endtask

  task automatic push_pixel(pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_red_level = px.level[CH_RED];
    in_green_level = px.level[CH_GREEN];
    in_blue_level = px.level[CH_BLUE];
    in_pixel_column = px.column;
    in_pixel_row = px.row;
    in_frame_end = px.frame_end;
    do @(posedge clk); while (in_stall);
    predict_centroids(px);
  endtask

  function automatic pixel_t make_pixel(int unsigned r, int unsigned g, int unsigned b,
                                        int unsigned col, int unsigned row, bit fe);
    pixel_t px;
    px.level[CH_RED] = LEVEL_W'(r);
    px.level[CH_GREEN] = LEVEL_W'(g);
    px.level[CH_BLUE] = LEVEL_W'(b);
    px.column = COL_W'(col);
    px.row = ROW_W'(row);
    px.frame_end = fe;
    return px;
  endfunction

  function automatic logic [LEVEL_W-1:0] random_level();
    int t;
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: begin
        // hover around the threshold so both sides of the compare show up
        t = int'(thr_model) + int'($urandom_range(4)) - 2;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return LEVEL_W'(t);
      end
      default: return LEVEL_W'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t random_pixel(bit fe);
    pixel_t px;
    for (int ch = 0; ch < CH_COUNT; ch++) px.level[ch] = random_level();
    case ($urandom_range(7))
      0: px.column = '0;
      1: px.column = '1;
      default: px.column = COL_W'($urandom_range(511));
    endcase
    case ($urandom_range(7))
      0: px.row = '0;
      1: px.row = '1;
      default: px.row = ROW_W'($urandom_range(255));
    endcase
    px.frame_end = fe;
    return px;
  endfunction

  // drop valid, let every expected centroid come out, then let the back end settle
  task automatic wait_for_centroids();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == THRESHOLD_ADDR) thr_model = data[LEVEL_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic cfg_check_threshold();
    logic [CFG_DATA_W-1:0] data;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = THRESHOLD_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (data[LEVEL_W-1:0] != thr_model) report_mismatch("threshold readback",
                                                          data[LEVEL_W-1:0], thr_model);
  endtask

  task automatic test_reset_threshold();
    cfg_check_threshold();
  endtask

  task automatic test_directed_frames();
    // one pixel at the far corner, every channel at full scale
    push_pixel(make_pixel(255, 255, 255, 511, 255, 1));
    // origin, just above the threshold
    push_pixel(make_pixel(231, 231, 231, 0, 0, 1));
    // exactly at the threshold is no hit: centroids held, nothing found
    push_pixel(make_pixel(230, 230, 230, 100, 50, 1));
    // truncating quotient, channels hit on different pixels
    push_pixel(make_pixel(255, 0, 0, 0, 1, 0));
    push_pixel(make_pixel(255, 240, 0, 1, 2, 0));
    push_pixel(make_pixel(0, 0, 0, 300, 200, 1));
    // empty frame
    push_pixel(make_pixel(0, 0, 0, 511, 255, 1));
    // mixed frame with the closing pixel itself a hit
    push_pixel(make_pixel(0, 0, 250, 510, 254, 0));
    push_pixel(make_pixel(231, 0, 255, 3, 7, 0));
    push_pixel(make_pixel(0, 255, 231, 256, 128, 1));
    // back-to-back frame ends fill the frame queue
    for (int k = 0; k < 8; k++) push_pixel(random_pixel(1'b1));
    wait_for_centroids();
  endtask

  task automatic test_threshold_extremes();
    cfg_write(THRESHOLD_ADDR, '0);
    cfg_check_threshold();
    // an unmapped register index leaves the threshold alone
    cfg_write(UNMAPPED_ADDR, 32'd77);
    cfg_check_threshold();
    push_pixel(make_pixel(1, 0, 1, 17, 33, 0));
    push_pixel(make_pixel(0, 1, 1, 400, 2, 1));
    wait_for_centroids();
    cfg_write(THRESHOLD_ADDR, 32'hFFFF_FFFF);
    cfg_check_threshold();
    push_pixel(make_pixel(255, 255, 255, 511, 255, 0));
    push_pixel(make_pixel(255, 255, 255, 12, 9, 1));
    wait_for_centroids();
  endtask

  task automatic run_traffic_phase(int unsigned n_pixels, int unsigned idle_pct,
                                   int unsigned stall_pct, int unsigned thr);
    int unsigned sent;
    int unsigned len;
    cfg_write(THRESHOLD_ADDR, CFG_DATA_W'(thr));
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_pixels) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
      for (int unsigned k = 0; k < len; k++) push_pixel(random_pixel(k == len - 1));
      sent += len;
    end
    wait_for_centroids();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(375, 0, 0, $urandom_range(255));
    run_traffic_phase(375, 85, 0, 0);
    run_traffic_phase(375, 0, 85, 180);
    run_traffic_phase(375, 34, 34, $urandom_range(255));
  endtask

  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < receiver_stall_pct);
  end

  // result checker: each accepted result against the oldest expected centroid set
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.center_x = {out_blue_center_x, out_green_center_x, out_red_center_x};
      got.center_y = {out_blue_center_y, out_green_center_y, out_red_center_y};
      got.found = {out_blue_found, out_green_found, out_red_found};
      if (pending_centroids.size() == 0) begin
        report_mismatch("unexpected result, found flags", got.found, 0);
      end else begin
        want = pending_centroids.pop_front();
        for (int ch = 0; ch < CH_COUNT; ch++) begin
          if (got.center_x[ch] != want.center_x[ch])
            report_mismatch({ch_name[ch], " center_x"}, got.center_x[ch], want.center_x[ch]);
          if (got.center_y[ch] != want.center_y[ch])
            report_mismatch({ch_name[ch], " center_y"}, got.center_y[ch], want.center_y[ch]);
          if (got.found[ch] != want.found[ch])
            report_mismatch({ch_name[ch], " found"}, got.found[ch], want.found[ch]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("three_channel_threshold_centroid_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_threshold();
    test_directed_frames();
    test_threshold_extremes();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("three_channel_threshold_centroid_top test passed");
    end else begin
      $display("three_channel_threshold_centroid_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
